// File: rtl/lci_pkg.sv
// Package with the shared types and constants of the line checkpoint indexer.
`timescale 1ns / 1ps

package lci_pkg;

  localparam int FIELD_W = 48;
  localparam int BND_W = 30;
  localparam int FIFO_AW = 2;
  localparam int FIFO_DEPTH = 1 << FIFO_AW;

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [4:0] STEP_MIN = 5'd12;
  localparam logic [4:0] STEP_MAX = 5'd30;
  localparam logic [4:0] STEP_RESET = 5'd22;

  localparam logic KIND_CHECKPOINT = 1'b0;
  localparam logic KIND_TOTALS = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [FIELD_W-1:0] line_number;
    logic [FIELD_W-1:0] byte_offset;
    logic               overflow;
    logic               final_res;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

// File: rtl/lci_if.sv
// Handshake interfaces for the byte input channel and the result channel.
`timescale 1ns / 1ps

interface lci_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface lci_out_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [lci_pkg::FIELD_W-1:0] line_number;
  logic [lci_pkg::FIELD_W-1:0] byte_offset;
  logic                        overflow;
  logic                        final_res;

  modport source (output valid, output kind, output line_number, output byte_offset,
                  output overflow, output final_res, input ready);
  modport sink (input valid, input kind, input line_number, input byte_offset,
                input overflow, input final_res, output ready);
endinterface

// File: rtl/line_checkpoint_indexer.sv
// Top level of the line checkpoint indexer: byte counters, checkpoint logic and result queue.
//
//   channel  direction  handshake          payload
//   in_ch    sink       valid / ready      data_byte, end_of_file
//   out_ch   source     valid / ready      kind, line_number, byte_offset, overflow, final_res
//   cfg      write      cfg_we             cfg_wdata (step_log2)
//
// A byte transfer lands in an input register; once there is room it updates the counters and
// pushes its zero, one or two results into a four-entry queue, one result leaving per transfer.
// Bytes are taken one per cycle while the queue holds at most two results; a byte waits only for
// queue space. rst_n clears counters, flags and queue and sets step_log2 to 22.
`timescale 1ns / 1ps

module line_checkpoint_indexer #(
  parameter int COUNT_WIDTH = 48
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata,
  lci_in_if.sink     in_ch,
  lci_out_if.source  out_ch
);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic [4:0] step_r;

  logic       stg_vld_r, stg_vld_nxt;
  logic [7:0] stg_byte_r;
  logic       stg_eof_r;

  logic [COUNT_WIDTH-1:0] bytes_r, bytes_nxt;
  logic [COUNT_WIDTH-1:0] lines_r, lines_nxt;
  logic prev_nl_r, prev_nl_nxt;
  logic pending_r, pending_nxt;
  logic sat_r, sat_nxt;
  logic resolved_r, resolved_nxt;

  logic                   room;
  logic                   fire;
  logic                   in_acc;
  logic [4:0]             sh;
  logic [lci_pkg::BND_W-1:0] mask;
  logic                   is_nl;
  logic                   at_zero;
  logic                   at_bnd;
  logic                   cp_a;
  logic                   cp_b;
  logic                   pend1;
  logic [COUNT_WIDTH-1:0] bc1;
  logic [COUNT_WIDTH-1:0] nc1;
  logic [COUNT_WIDTH-1:0] total_lines;
  logic                   sat1, sat2, sat3;
  lci_pkg::result_t       res_a, res_b, res_t;
  lci_pkg::push_t         push;

  function automatic logic [lci_pkg::FIELD_W-1:0] to_field(input logic [COUNT_WIDTH-1:0] v);
    logic [63:0] ext;
    ext = 64'(v);
    return ext[lci_pkg::FIELD_W-1:0];
  endfunction

  assign fire = stg_vld_r && room;
  assign in_ch.ready = !stg_vld_r || room;
  assign in_acc = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= lci_pkg::STEP_RESET;
    end else if (cfg_we) begin
      step_r <= cfg_wdata;
    end
  end

  always_comb begin
    stg_vld_nxt = stg_vld_r;
    if (in_acc) begin
      stg_vld_nxt = 1'b1;
    end else if (fire) begin
      stg_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= stg_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      stg_byte_r <= in_ch.data_byte;
      stg_eof_r <= in_ch.end_of_file;
    end
  end

  always_comb begin
    if (step_r < lci_pkg::STEP_MIN) begin
      sh = lci_pkg::STEP_MIN;
    end else if (step_r > lci_pkg::STEP_MAX) begin
      sh = lci_pkg::STEP_MAX;
    end else begin
      sh = step_r;
    end
    mask = ~({lci_pkg::BND_W{1'b1}} << sh);

    is_nl = stg_byte_r == lci_pkg::NEWLINE_BYTE;
    at_zero = bytes_r == '0;
    at_bnd = !at_zero && ((bytes_r[lci_pkg::BND_W-1:0] & mask) == '0);

    cp_a = at_zero || (at_bnd && prev_nl_r && !resolved_r);
    pend1 = pending_r || (at_bnd && !prev_nl_r);

    bc1 = (bytes_r == CNT_MAX) ? CNT_MAX : bytes_r + COUNT_WIDTH'(1);
    sat1 = sat_r || (bytes_r == CNT_MAX);

    nc1 = lines_r;
    sat2 = sat1;
    if (is_nl) begin
      nc1 = (lines_r == CNT_MAX) ? CNT_MAX : lines_r + COUNT_WIDTH'(1);
      sat2 = sat1 || (lines_r == CNT_MAX);
    end

    cp_b = is_nl && pend1;

    total_lines = nc1;
    sat3 = sat2;
    if (!is_nl) begin
      total_lines = (nc1 == CNT_MAX) ? CNT_MAX : nc1 + COUNT_WIDTH'(1);
      sat3 = sat2 || (nc1 == CNT_MAX);
    end
  end

  always_comb begin
    res_a.kind = lci_pkg::KIND_CHECKPOINT;
    res_a.line_number = at_zero ? '0 : to_field(lines_r);
    res_a.byte_offset = to_field(bytes_r);
    res_a.overflow = sat_r;
    res_a.final_res = 1'b0;

    res_b.kind = lci_pkg::KIND_CHECKPOINT;
    res_b.line_number = to_field(nc1);
    res_b.byte_offset = to_field(bc1);
    res_b.overflow = sat2;
    res_b.final_res = 1'b0;

    res_t.kind = lci_pkg::KIND_TOTALS;
    res_t.line_number = to_field(total_lines);
    res_t.byte_offset = to_field(bc1);
    res_t.overflow = sat3;
    res_t.final_res = 1'b1;

    push.cnt = '0;
    if (fire) begin
      push.cnt = 2'(cp_a) + 2'(cp_b) + 2'(stg_eof_r);
    end
    push.first = cp_a ? res_a : (cp_b ? res_b : res_t);
    push.second = (cp_a && cp_b) ? res_b : res_t;
  end

  always_comb begin
    bytes_nxt = bytes_r;
    lines_nxt = lines_r;
    prev_nl_nxt = prev_nl_r;
    pending_nxt = pending_r;
    sat_nxt = sat_r;
    resolved_nxt = resolved_r;
    if (fire) begin
      if (stg_eof_r) begin
        bytes_nxt = '0;
        lines_nxt = '0;
        prev_nl_nxt = 1'b0;
        pending_nxt = 1'b0;
        sat_nxt = 1'b0;
        resolved_nxt = 1'b0;
      end else begin
        bytes_nxt = bc1;
        lines_nxt = nc1;
        prev_nl_nxt = is_nl;
        pending_nxt = pend1 && !is_nl;
        sat_nxt = sat2;
        resolved_nxt = cp_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_r <= '0;
      lines_r <= '0;
      prev_nl_r <= 1'b0;
      pending_r <= 1'b0;
      sat_r <= 1'b0;
      resolved_r <= 1'b0;
    end else begin
      bytes_r <= bytes_nxt;
      lines_r <= lines_nxt;
      prev_nl_r <= prev_nl_nxt;
      pending_r <= pending_nxt;
      sat_r <= sat_nxt;
      resolved_r <= resolved_nxt;
    end
  end

  lci_result_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule

// File: rtl/lci_result_fifo.sv
// Result queue taking up to two results per cycle and giving one per transfer.
`timescale 1ns / 1ps

module lci_result_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  lci_pkg::push_t  push,
  output logic            room,
  lci_out_if.source       out_ch
);

  lci_pkg::result_t mem [lci_pkg::FIFO_DEPTH];

  logic [lci_pkg::FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [lci_pkg::FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [lci_pkg::FIFO_AW:0]   count_r, count_nxt;
  logic                        pop;
  lci_pkg::result_t            head;

  assign pop = out_ch.valid && out_ch.ready;
  assign room = count_r <= (lci_pkg::FIFO_AW + 1)'(lci_pkg::FIFO_DEPTH - 2);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + lci_pkg::FIFO_AW'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + lci_pkg::FIFO_AW'(pop);
    count_nxt = count_r + (lci_pkg::FIFO_AW + 1)'(push.cnt)
                - (lci_pkg::FIFO_AW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr_r] <= push.first;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr_r + lci_pkg::FIFO_AW'(1)] <= push.second;
    end
  end

  assign head = mem[rd_ptr_r];

  assign out_ch.valid = count_r != '0;
  assign out_ch.kind = head.kind;
  assign out_ch.line_number = head.line_number;
  assign out_ch.byte_offset = head.byte_offset;
  assign out_ch.overflow = head.overflow;
  assign out_ch.final_res = head.final_res;

endmodule

// File: bench/tb_top.sv
// Self-checking testbench for the line checkpoint indexer, driving byte streams and checking records.
`timescale 1ns / 1ps

module tb_top;

  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_PER_PHASE = 100;
  localparam int NUM_PHASES = 6;
  localparam logic [lci_pkg::FIELD_W-1:0] ONE = lci_pkg::FIELD_W'(1);

  typedef struct packed {
    logic [7:0] data;
    logic       eof;
  } file_byte_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [4:0] cfg_wdata;

  lci_in_if  in_ch ();
  lci_out_if out_ch ();

  line_checkpoint_indexer i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  file_byte_t       file_bytes_q[$];
  lci_pkg::result_t records_q[$];
  int               send_idle_pct;
  int               recv_idle_pct;
  int               mismatch_cnt = 0;
  int               stall_cnt = 0;

  logic [4:0]                  step_log2;
  logic [lci_pkg::FIELD_W-1:0] bytes_seen;
  logic [lci_pkg::FIELD_W-1:0] lines_seen;
  logic                        last_was_nl;
  logic                        boundary_open;
  logic                        counter_sat;
  logic                        just_resolved;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [lci_pkg::FIELD_W-1:0] bump(
    input logic [lci_pkg::FIELD_W-1:0] v);
    if (&v) begin
      counter_sat = 1'b1;
      return v;
    end
    return v + ONE;
  endfunction

  function automatic void clear_file();
    bytes_seen = '0;
    lines_seen = '0;
    last_was_nl = 1'b0;
    boundary_open = 1'b0;
    counter_sat = 1'b0;
    just_resolved = 1'b0;
  endfunction

  function automatic void add_record(input logic kind,
                                     input logic [lci_pkg::FIELD_W-1:0] line,
                                     input logic [lci_pkg::FIELD_W-1:0] offs,
                                     input logic fin);
    lci_pkg::result_t r;
    r.kind = kind;
    r.line_number = line;
    r.byte_offset = offs;
    r.overflow = counter_sat;
    r.final_res = fin;
    records_q.push_back(r);
  endfunction

  function automatic void index_byte(input logic [7:0] b, input logic eof);
    logic [4:0]                  sh;
    logic [lci_pkg::FIELD_W-1:0] pos;
    logic [lci_pkg::FIELD_W-1:0] total;
    logic                        is_nl;
    sh = (step_log2 < lci_pkg::STEP_MIN) ? lci_pkg::STEP_MIN :
         (step_log2 > lci_pkg::STEP_MAX) ? lci_pkg::STEP_MAX : step_log2;
    pos = bytes_seen;
    is_nl = (b == lci_pkg::NEWLINE_BYTE);
    if (pos == '0) begin
      add_record(lci_pkg::KIND_CHECKPOINT, '0, '0, 1'b0);
    end else if ((pos & ((ONE << sh) - ONE)) == '0) begin
      if (last_was_nl) begin
        if (!just_resolved) add_record(lci_pkg::KIND_CHECKPOINT, lines_seen, pos, 1'b0);
      end else begin
        boundary_open = 1'b1;
      end
    end
    just_resolved = 1'b0;
    bytes_seen = bump(bytes_seen);
    if (is_nl) begin
      lines_seen = bump(lines_seen);
      if (boundary_open) begin
        add_record(lci_pkg::KIND_CHECKPOINT, lines_seen, bytes_seen, 1'b0);
        boundary_open = 1'b0;
        just_resolved = 1'b1;
      end
    end
    last_was_nl = is_nl;
    if (eof) begin
      total = is_nl ? lines_seen : bump(lines_seen);
      add_record(lci_pkg::KIND_TOTALS, total, bytes_seen, 1'b1);
      clear_file();
    end
  endfunction

  function automatic void push_byte(input logic [7:0] b, input logic eof);
    file_bytes_q.push_back('{b, eof});
  endfunction

  function automatic int add_random_file(input int min_len, input int max_len,
                                         input int nl_per10k);
    int         len;
    logic [7:0] b;
    len = $urandom_range(max_len, min_len);
    for (int i = 0; i < len; i++) begin
      b = ($urandom_range(9999) < nl_per10k) ? lci_pkg::NEWLINE_BYTE :
                                               8'($urandom_range(255));
      push_byte(b, i == len - 1);
    end
    return len;
  endfunction

  task automatic drain();
    do @(negedge clk);
    while (file_bytes_q.size() != 0 || in_ch.valid || records_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_step(input logic [4:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    step_log2 = v;
  endtask

  always @(posedge clk) begin
    file_byte_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (file_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = file_bytes_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= nxt.data;
        in_ch.end_of_file <= nxt.eof;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    lci_pkg::result_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) index_byte(in_ch.data_byte, in_ch.end_of_file);
      if (out_ch.valid && out_ch.ready) begin
        if (records_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("Unexpected record: kind %0d line %0d offset %0d ovf %0d final %0d",
                     out_ch.kind, out_ch.line_number, out_ch.byte_offset,
                     out_ch.overflow, out_ch.final_res);
        end else begin
          want = records_q.pop_front();
          if (out_ch.kind !== want.kind || out_ch.line_number !== want.line_number ||
              out_ch.byte_offset !== want.byte_offset || out_ch.overflow !== want.overflow ||
              out_ch.final_res !== want.final_res) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("Record mismatch, expected kind %0d line %0d offset %0d ovf %0d final %0d",
                       want.kind, want.line_number, want.byte_offset,
                       want.overflow, want.final_res);
              $display("                 actual   kind %0d line %0d offset %0d ovf %0d final %0d",
                       out_ch.kind, out_ch.line_number, out_ch.byte_offset,
                       out_ch.overflow, out_ch.final_res);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt == STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    int         added;
    logic [4:0] phase_step;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.end_of_file = 1'b0;
    out_ch.ready = 1'b0;
    send_idle_pct = 7;
    recv_idle_pct = 85;
    step_log2 = lci_pkg::STEP_RESET;
    clear_file();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    push_byte(8'hFF, 1'b1);
    push_byte(lci_pkg::NEWLINE_BYTE, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(lci_pkg::NEWLINE_BYTE, 1'b0);
    push_byte(lci_pkg::NEWLINE_BYTE, 1'b0);
    push_byte(8'h80, 1'b1);
    push_byte(8'h55, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h0B, 1'b0);
    push_byte(8'h09, 1'b0);
    push_byte(lci_pkg::NEWLINE_BYTE, 1'b1);
    push_byte(8'h8A, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(lci_pkg::NEWLINE_BYTE, 1'b0);
    push_byte(8'h01, 1'b1);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      send_idle_pct = (p < 2) ? 7 : (p < 4) ? 85 : 0;
      recv_idle_pct = (p < 2) ? 85 : (p < 4) ? 7 : 0;
      case (p)
        0: phase_step = 5'd0;
        1: phase_step = 5'd31;
        2: phase_step = 5'd12;
        3: phase_step = 5'd30;
        4: phase_step = lci_pkg::STEP_RESET;
        default: phase_step = 5'($urandom_range(31));
      endcase
      write_step(phase_step);
      added = 0;
      while (added < RANDOM_PER_PHASE) added += add_random_file(1, 24, 2000);
      drain();
    end

    if (mismatch_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
